FILE: hw/rtl/msfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfr_pkg
// Shared types, codes and the CRC-16 byte update for the Modbus slave frame
// receiver.
// ----------------------------------------------------------------------------
package msfr_pkg;

    localparam int WRITE_FRAME_LEN_DEF = 23;
    localparam int SHORT_FRAME_LEN     = 8;
    localparam int SHORT_CAP_LEN       = 6;
    localparam int PAYLOAD_FIRST       = 7;
    localparam int PAYLOAD_LAST        = 15;
    localparam int PAYLOAD_DEPTH       = PAYLOAD_LAST - PAYLOAD_FIRST + 1;
    localparam int FUNC_POS            = 1;
    localparam int COUNT_POS           = 6;

    localparam logic [7:0]  SLAVE_ADDRESS_RST = 8'h02;
    localparam logic [7:0]  SILENCE_LIMIT_RST = 8'd10;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;

    localparam logic [7:0] FN_READ  = 8'h03;
    localparam logic [7:0] FN_WRITE = 8'h10;
    localparam logic [7:0] FN_TEST  = 8'hAA;

    localparam logic       CFG_SLAVE_ADDRESS = 1'b0;
    localparam logic       CFG_SILENCE_LIMIT = 1'b1;

    localparam logic       OP_BYTE = 1'b0;
    localparam logic       OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_READ_OK    = 3'd0,
        ST_WRITE_OK   = 3'd1,
        ST_TEST_OK    = 3'd2,
        ST_CRC_ERROR  = 3'd3,
        ST_UNKNOWN_FN = 3'd4,
        ST_TIMEOUT    = 3'd5
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [7:0]         function_code;
        logic signed [15:0] temp_calibration;
        logic signed [15:0] humidity_calibration;
        logic [15:0]        max_sterilize_time;
        logic [7:0]         sterilize_mode;
        logic [7:0]         lock_setting;
        logic [7:0]         door_state;
    } t_result;

    typedef struct packed {
        logic [7:0] slave_address;
        logic [7:0] silence_limit;
    } t_cfg;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/msfr_frame_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfr_frame_core
// Input register, frame state and one-pass decode of each byte or tick into
// at most one result per item.
// ----------------------------------------------------------------------------
module msfr_frame_core
    import msfr_pkg::*;
#(
    parameter int WRITE_FRAME_LEN = WRITE_FRAME_LEN_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    output logic    o_stall,
    input  logic    i_opcode,
    input  logic [7:0] i_data_byte,
    input  logic    i_room,
    output logic    o_res_valid,
    output t_result o_res
);

    localparam int         PW      = $clog2(WRITE_FRAME_LEN + 1);
    localparam logic [8:0] TOTAL_W = 9'(WRITE_FRAME_LEN);
    localparam logic [8:0] TOTAL_S = 9'(SHORT_FRAME_LEN);

    logic          r_in_valid;
    logic          r_in_op;
    logic [7:0]    r_in_byte;
    logic          r_busy,  n_busy;
    logic [PW-1:0] r_pos,   n_pos;
    logic [7:0]    r_func,  n_func;
    logic [7:0]    r_count, n_count;
    logic [15:0]   r_crc,   n_crc;
    logic [15:0]   r_cap,   n_cap;
    logic          r_match, n_match;
    logic [7:0]    r_sil,   n_sil;
    logic [7:0]    r_pay [PAYLOAD_DEPTH];

    logic          process;
    logic          pay_we;
    logic [3:0]    pay_idx;
    logic [8:0]    pos_x;
    logic [8:0]    next_x;
    logic [8:0]    cap_len;
    logic [8:0]    total;
    logic          fits;
    logic          is_write;
    logic [7:0]    sil_inc;
    logic [15:0]   crc_upd;

    assign process = r_in_valid && i_room;
    assign o_stall = r_in_valid && !i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_op   <= i_opcode;
            r_in_byte <= i_data_byte;
        end
    end

    always_comb begin
        n_busy      = r_busy;
        n_pos       = r_pos;
        n_func      = r_func;
        n_count     = r_count;
        n_crc       = r_crc;
        n_cap       = r_cap;
        n_match     = r_match;
        n_sil       = r_sil;
        pay_we      = 1'b0;
        pos_x       = {{(9 - PW){1'b0}}, r_pos};
        next_x      = pos_x + 9'd1;
        pay_idx     = 4'(pos_x - 9'(PAYLOAD_FIRST));
        sil_inc     = (r_sil == 8'hFF) ? r_sil : r_sil + 8'd1;
        crc_upd     = crc_byte(r_crc, r_in_byte);
        is_write    = 1'b0;
        cap_len     = 9'(SHORT_CAP_LEN);
        total       = TOTAL_S;
        fits        = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.function_code = r_func;

        if (process) begin
            if (r_in_op == OP_TICK) begin
                if (r_busy) begin
                    n_sil = sil_inc;
                    if (sil_inc >= i_cfg.silence_limit) begin
                        n_sil       = 8'd0;
                        n_busy      = 1'b0;
                        n_pos       = '0;
                        o_res_valid = 1'b1;
                        o_res.status = ST_TIMEOUT;
                    end
                end
            end else begin
                n_sil = 8'd0;
                if (!r_busy) begin
                    if (r_in_byte == i_cfg.slave_address) begin
                        n_busy  = 1'b1;
                        n_pos   = PW'(1);
                        n_func  = 8'd0;
                        n_count = 8'd0;
                        n_crc   = crc_byte(CRC_INIT, r_in_byte);
                        n_cap   = 16'd0;
                        n_match = 1'b0;
                    end
                end else begin
                    if (pos_x == 9'(FUNC_POS)) begin
                        n_func = r_in_byte;
                    end
                    if (pos_x == 9'(COUNT_POS)) begin
                        n_count = r_in_byte;
                    end
                    pay_we = (pos_x >= 9'(PAYLOAD_FIRST)) && (pos_x <= 9'(PAYLOAD_LAST));
                    o_res.function_code = n_func;

                    if (n_func != FN_READ && n_func != FN_WRITE && n_func != FN_TEST) begin
                        n_busy       = 1'b0;
                        n_pos        = '0;
                        o_res_valid  = 1'b1;
                        o_res.status = ST_UNKNOWN_FN;
                    end else begin
                        is_write = (n_func == FN_WRITE);
                        if (is_write) begin
                            cap_len = {1'b0, n_count} + 9'(PAYLOAD_FIRST);
                            total   = TOTAL_W;
                        end
                        fits = (cap_len + 9'd2) <= total;
                        if (fits && pos_x == cap_len) begin
                            n_match = (r_in_byte == r_cap[7:0]);
                        end else if (fits && pos_x == cap_len + 9'd1) begin
                            n_match = r_match && (r_in_byte == r_cap[15:8]);
                        end
                        n_crc = crc_upd;
                        if (next_x == cap_len) begin
                            n_cap = crc_upd;
                        end
                        n_pos = PW'(next_x);
                        if (next_x >= total) begin
                            n_busy      = 1'b0;
                            n_pos       = '0;
                            o_res_valid = 1'b1;
                            if (!(n_match && fits)) begin
                                o_res.status = ST_CRC_ERROR;
                            end else if (n_func == FN_READ) begin
                                o_res.status = ST_READ_OK;
                            end else if (is_write) begin
                                o_res.status               = ST_WRITE_OK;
                                o_res.temp_calibration     = {r_pay[0], r_pay[1]};
                                o_res.humidity_calibration = {r_pay[2], r_pay[3]};
                                o_res.max_sterilize_time   = {r_pay[4], r_pay[5]};
                                o_res.sterilize_mode       = r_pay[6];
                                o_res.lock_setting         = r_pay[7];
                                o_res.door_state           = r_pay[8];
                            end else begin
                                o_res.status = ST_TEST_OK;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pos   <= '0;
            r_func  <= 8'd0;
            r_count <= 8'd0;
            r_crc   <= CRC_INIT;
            r_cap   <= 16'd0;
            r_match <= 1'b0;
            r_sil   <= 8'd0;
        end else begin
            r_busy  <= n_busy;
            r_pos   <= n_pos;
            r_func  <= n_func;
            r_count <= n_count;
            r_crc   <= n_crc;
            r_cap   <= n_cap;
            r_match <= n_match;
            r_sil   <= n_sil;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pay_we) begin
            r_pay[pay_idx] <= r_in_byte;
        end
    end

    a_idle_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_pos == '0)
        else $error("idle frame with nonzero byte position");

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {{(9 - PW){1'b0}}, r_pos} < TOTAL_W)
        else $error("byte position past write frame length");

    a_result_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !r_busy)
        else $error("frame still busy after its result");

    a_write_ok_func: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_WRITE_OK) |-> o_res.function_code == FN_WRITE)
        else $error("write ok reported for non-write function");

endmodule

FILE: hw/rtl/msfr_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfr_result_queue
// Two-entry result queue that decouples the frame core from output stalls.
// ----------------------------------------------------------------------------
module msfr_result_queue
    import msfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    logic    r_wr_ptr;
    logic    r_rd_ptr;
    logic [1:0] r_count, n_count;
    t_result r_q [2];
    logic    pop;

    assign o_valid = (r_count != 2'd0);
    assign o_room  = (r_count != 2'd2);
    assign pop     = o_valid && !i_stall;
    assign o_res   = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd2) |-> !i_push)
        else $error("push into full result queue");

    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

endmodule

FILE: hw/rtl/modbus_slave_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_slave_frame_receiver
// Modbus RTU slave frame receiver with running CRC-16 check.
//
// Input channel (i_valid / o_stall): one item per transfer, either a received
// byte (i_opcode 0) or a 1 ms tick (i_opcode 1). Output channel (o_valid /
// i_stall): one result per finished, aborted or timed-out frame, carrying the
// status, function code and, for a good write, the six decoded settings.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 slave address, 1 silence limit) at the clock edge; write only when idle.
// Throughput: one item per cycle while o_stall is low; the byte CRC update is
// a single pass. An item is held in the input register and decoded from
// there; its result is registered in a two-entry result queue and presented
// from it. When the receiver stalls, the queue absorbs up to two results;
// after that o_stall rises and the input register holds its item.
// Reset: synchronous, active low; frame idle, CRC at 0xFFFF, slave address 2,
// silence limit 10, result queue empty.
// ----------------------------------------------------------------------------
module modbus_slave_frame_receiver
    import msfr_pkg::*;
#(
    parameter int WRITE_FRAME_LEN = WRITE_FRAME_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_opcode,
    input  logic [7:0]         i_data_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic [7:0]         o_function_code,
    output logic signed [15:0] o_temp_calibration,
    output logic signed [15:0] o_humidity_calibration,
    output logic [15:0]        o_max_sterilize_time,
    output logic [7:0]         o_sterilize_mode,
    output logic [7:0]         o_lock_setting,
    output logic [7:0]         o_door_state
);

    t_cfg    r_cfg;
    logic    room;
    logic    res_valid;
    t_result res;
    t_result out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_address <= SLAVE_ADDRESS_RST;
            r_cfg.silence_limit <= SILENCE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index[0])
                CFG_SLAVE_ADDRESS: r_cfg.slave_address <= i_cfg_data;
                CFG_SILENCE_LIMIT: r_cfg.silence_limit <= i_cfg_data;
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    msfr_frame_core #(
        .WRITE_FRAME_LEN(WRITE_FRAME_LEN)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_opcode    (i_opcode),
        .i_data_byte (i_data_byte),
        .i_room      (room),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    msfr_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (out_res)
    );

    assign o_status               = out_res.status;
    assign o_function_code        = out_res.function_code;
    assign o_temp_calibration     = out_res.temp_calibration;
    assign o_humidity_calibration = out_res.humidity_calibration;
    assign o_max_sterilize_time   = out_res.max_sterilize_time;
    assign o_sterilize_mode       = out_res.sterilize_mode;
    assign o_lock_setting         = out_res.lock_setting;
    assign o_door_state           = out_res.door_state;

endmodule

FILE: sim/msfr_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msfr_frame_checker
// Watches both channels and the register port of the Modbus frame receiver.
// Every accepted byte or tick runs through a frame decoder with its own CRC-16,
// which queues the status and settings that the block must report. Every
// result transfer is then compared field by field against the oldest entry.
// ----------------------------------------------------------------------------
module msfr_frame_checker
    import msfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_opcode,
    input  logic [7:0]         i_data_byte,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [2:0]         i_status,
    input  logic [7:0]         i_function_code,
    input  logic signed [15:0] i_temp_calibration,
    input  logic signed [15:0] i_humidity_calibration,
    input  logic [15:0]        i_max_sterilize_time,
    input  logic [7:0]         i_sterilize_mode,
    input  logic [7:0]         i_lock_setting,
    input  logic [7:0]         i_door_state,
    output int                 o_pending,
    output int                 o_errors
);

    localparam int FRAME_LEN_WRITE = WRITE_FRAME_LEN_DEF;
    localparam int PRINT_LIMIT     = 50;

    logic [7:0]  own_address;
    logic [7:0]  silence_max;
    logic        in_frame;
    int          byte_pos;
    logic [7:0]  frame_fn;
    logic [7:0]  byte_count;
    logic [15:0] crc_acc;
    logic [15:0] crc_expect;
    logic        crc_good;
    logic [7:0]  setting_bytes [PAYLOAD_DEPTH];
    logic [7:0]  quiet_ticks;
    t_result     pending_results [$];

    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] din);
        logic [15:0] c;
        c = acc ^ {8'h00, din};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic report_error(input string msg);
        if (o_errors < PRINT_LIMIT) begin
            $display("[%0t] ERROR: %s", $time, msg);
        end
        o_errors++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_error($sformatf("%s got %04h want %04h", name, got, want));
        end
    endtask

    task automatic decode_event(input logic op, input logic [7:0] din);
        t_result r;
        int      p;
        int      n;
        int      cap;
        int      total;
        bit      fits;
        r = '0;
        if (op == OP_TICK) begin
            if (!in_frame) return;
            if (quiet_ticks != 8'hFF) quiet_ticks++;
            if (quiet_ticks >= silence_max) begin
                quiet_ticks     = '0;
                in_frame        = 1'b0;
                byte_pos        = 0;
                r.status        = ST_TIMEOUT;
                r.function_code = frame_fn;
                pending_results.push_back(r);
            end
            return;
        end
        quiet_ticks = '0;
        if (!in_frame) begin
            if (din == own_address) begin
                in_frame   = 1'b1;
                byte_pos   = 1;
                frame_fn   = '0;
                byte_count = '0;
                crc_acc    = crc16_step(CRC_INIT, din);
                crc_expect = '0;
                crc_good   = 1'b0;
            end
            return;
        end
        p = byte_pos;
        if (p == FUNC_POS) begin
            frame_fn = din;
        end else if (p == COUNT_POS) begin
            byte_count = din;
        end
        if (p >= PAYLOAD_FIRST && p <= PAYLOAD_LAST) setting_bytes[p - PAYLOAD_FIRST] = din;
        if (frame_fn != FN_READ && frame_fn != FN_WRITE && frame_fn != FN_TEST) begin
            in_frame        = 1'b0;
            byte_pos        = 0;
            r.status        = ST_UNKNOWN_FN;
            r.function_code = frame_fn;
            pending_results.push_back(r);
            return;
        end
        if (frame_fn == FN_WRITE) begin
            cap   = int'(byte_count) + 7;
            total = FRAME_LEN_WRITE;
        end else begin
            cap   = SHORT_CAP_LEN;
            total = SHORT_FRAME_LEN;
        end
        fits = (cap + 2 <= total);
        if (fits) begin
            if (p == cap) begin
                crc_good = (din == crc_expect[7:0]);
            end else if (p == cap + 1) begin
                crc_good = crc_good && (din == crc_expect[15:8]);
            end
        end
        crc_acc = crc16_step(crc_acc, din);
        n = p + 1;
        if (n == cap) crc_expect = crc_acc;
        byte_pos = n % 32;
        if (n >= total) begin
            in_frame = 1'b0;
            byte_pos = 0;
            if (!(crc_good && fits)) begin
                r.status = ST_CRC_ERROR;
            end else if (frame_fn == FN_READ) begin
                r.status = ST_READ_OK;
            end else if (frame_fn == FN_WRITE) begin
                r.status = ST_WRITE_OK;
            end else begin
                r.status = ST_TEST_OK;
            end
            r.function_code = frame_fn;
            if (r.status == ST_WRITE_OK) begin
                r.temp_calibration     = {setting_bytes[0], setting_bytes[1]};
                r.humidity_calibration = {setting_bytes[2], setting_bytes[3]};
                r.max_sterilize_time   = {setting_bytes[4], setting_bytes[5]};
                r.sterilize_mode       = setting_bytes[6];
                r.lock_setting         = setting_bytes[7];
                r.door_state           = setting_bytes[8];
            end
            pending_results.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            own_address = SLAVE_ADDRESS_RST;
            silence_max = SILENCE_LIMIT_RST;
            in_frame    = 1'b0;
            byte_pos    = 0;
            frame_fn    = '0;
            byte_count  = '0;
            crc_acc     = CRC_INIT;
            crc_expect  = '0;
            crc_good    = 1'b0;
            quiet_ticks = '0;
            foreach (setting_bytes[k]) setting_bytes[k] = '0;
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_error($sformatf("result with nothing expected: status %0d function %02h",
                                           i_status, i_function_code));
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 16'(i_status), 16'(want.status));
                    check_field("function_code", 16'(i_function_code),
                                16'(want.function_code));
                    check_field("temp_calibration", i_temp_calibration,
                                want.temp_calibration);
                    check_field("humidity_calibration", i_humidity_calibration,
                                want.humidity_calibration);
                    check_field("max_sterilize_time", i_max_sterilize_time,
                                want.max_sterilize_time);
                    check_field("sterilize_mode", 16'(i_sterilize_mode),
                                16'(want.sterilize_mode));
                    check_field("lock_setting", 16'(i_lock_setting),
                                16'(want.lock_setting));
                    check_field("door_state", 16'(i_door_state), 16'(want.door_state));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SLAVE_ADDRESS: own_address = i_cfg_data;
                    CFG_SILENCE_LIMIT: silence_max = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) decode_event(i_opcode, i_data_byte);
        end
        o_pending = pending_results.size();
    end

endmodule

FILE: sim/tb_modbus_slave_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_slave_frame_receiver
// Drives bytes and ticks into the Modbus slave frame receiver: a directed set
// of read, test, write, bad checksum, unknown function and timeout frames,
// then random frames with noise under several address and silence settings.
// The sender runs in bursts, the receiver stalls on its own pattern, and the
// frame checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_modbus_slave_frame_receiver;
    import msfr_pkg::*;

    localparam int IDLE_LIMIT      = 2000;
    localparam int ITEMS_PER_PHASE = 220;
    localparam int SETTLE_CYCLES   = 6;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [0:0]         cfg_index = '0;
    logic [7:0]         cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic               in_opcode = OP_BYTE;
    logic [7:0]         in_byte   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         res_status;
    logic [7:0]         res_function;
    logic signed [15:0] res_temp;
    logic signed [15:0] res_humidity;
    logic [15:0]        res_max_time;
    logic [7:0]         res_mode;
    logic [7:0]         res_lock;
    logic [7:0]         res_door;
    int                 pending;
    int                 errors;

    logic [7:0]  cur_addr   = SLAVE_ADDRESS_RST;
    int          cur_limit  = SILENCE_LIMIT_RST;
    int          burst_left = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    int          stall_clock = 0;
    t_stall_mode stall_mode = STALL_NONE;
    logic [7:0]  frame_buf [$];

    modbus_slave_frame_receiver dut (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_we               (cfg_we),
        .i_cfg_index            (cfg_index),
        .i_cfg_data             (cfg_data),
        .i_valid                (in_valid),
        .o_stall                (in_stall),
        .i_opcode               (in_opcode),
        .i_data_byte            (in_byte),
        .o_valid                (out_valid),
        .i_stall                (out_stall),
        .o_status               (res_status),
        .o_function_code        (res_function),
        .o_temp_calibration     (res_temp),
        .o_humidity_calibration (res_humidity),
        .o_max_sterilize_time   (res_max_time),
        .o_sterilize_mode       (res_mode),
        .o_lock_setting         (res_lock),
        .o_door_state           (res_door)
    );

    msfr_frame_checker u_frame_checker (
        .i_clk                  (clk),
        .i_rst_n                (rst_n),
        .i_cfg_we               (cfg_we),
        .i_cfg_index            (cfg_index),
        .i_cfg_data             (cfg_data),
        .i_in_valid             (in_valid),
        .i_in_stall             (in_stall),
        .i_opcode               (in_opcode),
        .i_data_byte            (in_byte),
        .i_out_valid            (out_valid),
        .i_out_stall            (out_stall),
        .i_status               (res_status),
        .i_function_code        (res_function),
        .i_temp_calibration     (res_temp),
        .i_humidity_calibration (res_humidity),
        .i_max_sterilize_time   (res_max_time),
        .i_sterilize_mode       (res_mode),
        .i_lock_setting         (res_lock),
        .i_door_state           (res_door),
        .o_pending              (pending),
        .o_errors               (errors)
    );

    always #5 clk = ~clk;

    always @(negedge clk) begin
        stall_clock++;
        if (stall_clock % 150 == 0) stall_mode = t_stall_mode'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
            default:     out_stall <= ((stall_clock % 5) < 2);
        endcase
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        in_opcode <= op;
        in_byte   <= value;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_item(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_timeout();
        send_ticks((cur_limit == 0) ? 1 : cur_limit);
    endtask

    function automatic logic [15:0] frame_crc();
        logic [15:0] acc;
        acc = CRC_INIT;
        foreach (frame_buf[k]) begin
            acc ^= {8'h00, frame_buf[k]};
            for (int s = 0; s < 8; s++) begin
                acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
            end
        end
        return acc;
    endfunction

    function automatic void build_short(input logic [7:0] fn, input bit good);
        logic [15:0] crc;
        frame_buf.delete();
        frame_buf.push_back(cur_addr);
        frame_buf.push_back(fn);
        repeat (SHORT_CAP_LEN - 2) frame_buf.push_back(8'($urandom_range(0, 255)));
        crc = frame_crc();
        if (!good) crc ^= 16'(1) << $urandom_range(0, 15);
        frame_buf.push_back(crc[7:0]);
        frame_buf.push_back(crc[15:8]);
    endfunction

    function automatic void build_write(input logic [7:0] count, input bit good);
        logic [15:0] crc;
        int          cap;
        cap = int'(count) + 7;
        frame_buf.delete();
        frame_buf.push_back(cur_addr);
        frame_buf.push_back(FN_WRITE);
        repeat (COUNT_POS - 2) frame_buf.push_back(8'($urandom_range(0, 255)));
        frame_buf.push_back(count);
        if (cap + 2 <= WRITE_FRAME_LEN_DEF) begin
            while (frame_buf.size() < cap) frame_buf.push_back(8'($urandom_range(0, 255)));
            crc = frame_crc();
            if (!good) crc ^= 16'(1) << $urandom_range(0, 15);
            frame_buf.push_back(crc[7:0]);
            frame_buf.push_back(crc[15:8]);
        end
        while (frame_buf.size() < WRITE_FRAME_LEN_DEF) begin
            frame_buf.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic logic [7:0] random_write_count();
        return ($urandom_range(0, 7) != 0) ? 8'($urandom_range(0, 14))
                                           : 8'($urandom_range(15, 255));
    endfunction

    task automatic send_frame(input bit sprinkle);
        int safe;
        safe = (cur_limit > 1) ? cur_limit - 1 : 0;
        if (safe > 3) safe = 3;
        foreach (frame_buf[k]) begin
            send_item(OP_BYTE, frame_buf[k]);
            if (sprinkle && safe > 0 && $urandom_range(0, 7) == 0) begin
                send_ticks($urandom_range(1, safe));
            end
        end
    endtask

    task automatic random_frame();
        int         sel;
        int         keep;
        logic [7:0] fn;
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            build_short(FN_READ, 1'b1);
            send_frame(1'b1);
        end else if (sel < 32) begin
            build_short(FN_TEST, 1'b1);
            send_frame(1'b1);
        end else if (sel < 60) begin
            build_write(random_write_count(), 1'b1);
            send_frame(1'b1);
        end else if (sel < 70) begin
            if ($urandom_range(0, 1) == 0) begin
                build_short($urandom_range(0, 1) ? FN_READ : FN_TEST, 1'b0);
            end else begin
                build_write(8'($urandom_range(0, 14)), 1'b0);
            end
            send_frame(1'b1);
        end else if (sel < 78) begin
            do fn = 8'($urandom_range(0, 255));
            while (fn == FN_READ || fn == FN_WRITE || fn == FN_TEST);
            frame_buf.delete();
            frame_buf.push_back(cur_addr);
            frame_buf.push_back(fn);
            send_frame(1'b0);
        end else if (sel < 86) begin
            // cut the frame short, then let it go silent
            if ($urandom_range(0, 1) == 0) begin
                build_short($urandom_range(0, 1) ? FN_READ : FN_TEST, 1'b1);
            end else begin
                build_write(random_write_count(), 1'b1);
            end
            keep = $urandom_range(1, frame_buf.size() - 1);
            while (frame_buf.size() > keep) void'(frame_buf.pop_back());
            send_frame(1'b1);
            send_timeout();
        end else begin
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_item(OP_BYTE, 8'($urandom_range(0, 255)));
                end else begin
                    send_item(OP_TICK, 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_phase(input logic [7:0] addr, input int limit);
        // close any open frame, then hold until the block is idle
        send_timeout();
        drain();
        write_reg(CFG_SLAVE_ADDRESS, addr);
        write_reg(CFG_SILENCE_LIMIT, 8'(limit));
        cur_addr  = addr;
        cur_limit = limit;
    endtask

    task automatic random_phase();
        int target;
        target = items_sent + ITEMS_PER_PHASE;
        while (items_sent < target) random_frame();
    endtask

    initial begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(OP_TICK, 8'hFF);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        build_short(FN_READ, 1'b1);
        send_frame(1'b0);
        build_short(FN_TEST, 1'b1);
        send_frame(1'b0);
        build_short(FN_READ, 1'b0);
        send_frame(1'b0);
        frame_buf.delete();
        frame_buf.push_back(cur_addr);
        frame_buf.push_back(8'h00);
        send_frame(1'b0);
        frame_buf.delete();
        frame_buf.push_back(cur_addr);
        frame_buf.push_back(8'hFF);
        send_frame(1'b0);
        build_write(8'd8, 1'b1);
        send_frame(1'b0);
        build_write(8'd0, 1'b1);
        send_frame(1'b0);
        build_write(8'd14, 1'b1);
        send_frame(1'b0);
        build_write(8'd15, 1'b1);
        send_frame(1'b0);
        build_write(8'd255, 1'b1);
        send_frame(1'b0);
        build_write(8'd8, 1'b0);
        send_frame(1'b0);
        send_item(OP_BYTE, cur_addr);
        send_timeout();
        send_item(OP_BYTE, cur_addr);
        send_item(OP_BYTE, FN_READ);
        send_timeout();
        random_phase();

        set_phase(8'h00, 1);
        random_phase();
        set_phase(8'hFF, 255);
        random_phase();
        set_phase(8'($urandom_range(0, 255)), 0);
        random_phase();
        set_phase(8'($urandom_range(0, 255)), $urandom_range(2, 30));
        random_phase();

        send_timeout();
        drain();
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
